### rtl/rgbhsv_pkg.sv
// types and constants shared by the rgb to hsv converter
package rgbhsv_pkg;

  localparam int unsigned PIX_W          = 8;
  localparam int unsigned HUE_NUM_W      = 19;  // 255 * n, n below 6 * 255
  localparam int unsigned HUE_DEN_W      = 11;  // 6 * delta
  localparam int unsigned SAT_NUM_W      = 16;  // 255 * delta
  localparam int unsigned SAT_DEN_W      = 8;   // largest channel
  localparam int unsigned QUOT_W         = 8;
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES     = QUOT_W / BITS_PER_STAGE;
  localparam int unsigned N_STAGES       = DIV_STAGES + 2;

  // first stage: extremes of the pixel and the hue numerator
  typedef struct packed {
    logic [PIX_W-1:0]     mx;
    logic [PIX_W-1:0]     delta;
    logic [HUE_DEN_W-1:0] n;
  } prep_t;

  // divider stages: partial remainders, divisors and quotients for hue and saturation
  typedef struct packed {
    logic [HUE_NUM_W-1:0] hrem;
    logic [HUE_DEN_W-1:0] hden;
    logic [QUOT_W-1:0]    hq;
    logic [SAT_NUM_W-1:0] srem;
    logic [SAT_DEN_W-1:0] sden;
    logic [QUOT_W-1:0]    sq;
    logic [PIX_W-1:0]     bright;
  } quot_t;

endpackage

### rtl/rgb_to_hsv_converter.sv
// rgb to hsv pixel converter: pipelined top level
// Converts one 8-bit rgb pixel into 8-bit hue, saturation and brightness.
// Input channel: pixel_valid / pixel_stall with red, green, blue; a transaction
// completes at a clock edge with pixel_valid high and pixel_stall low.
// Output channel: hsv_valid / hsv_stall with hue, saturation, brightness, same rule.
// Six register stages lie between input transaction and hsv_valid; throughput is
// one pixel per clock while hsv_stall is low. Stage one finds max, min and the hue
// numerator, stage two forms the scaled dividends, and four divider stages retire two
// quotient bits each for the hue and saturation restoring dividers.
// Hue is floor(255 * n / (6 * delta)) with a full turn mapped to 255; saturation is
// floor(255 * delta / max); brightness is max. A grey pixel gives hue 0, saturation 0.
// Each stage holds its transaction while the next is full and stalled, and empty
// stages close up, so pixels are still taken while a result waits on hsv_stall.
// A stall never drops or repeats a transaction; pixel_stall rises only once every
// stage is full.
// Reset (rst, synchronous, active high) empties the pipeline; no other state.
module rgb_to_hsv_converter (
  input  logic       clk,
  input  logic       rst,
  input  logic       pixel_valid,
  output logic       pixel_stall,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       hsv_valid,
  input  logic       hsv_stall,
  output logic [7:0] hue,
  output logic [7:0] saturation,
  output logic [7:0] brightness
);

  localparam int unsigned NS = rgbhsv_pkg::N_STAGES;
  localparam int unsigned DS = rgbhsv_pkg::DIV_STAGES;

  logic [NS-1:0] vld;
  logic [NS-1:0] adv;

  rgbhsv_pkg::prep_t prep;
  rgbhsv_pkg::prep_t prep_next;
  rgbhsv_pkg::quot_t pipe      [DS+1];
  rgbhsv_pkg::quot_t pipe_next [DS+1];

  // a stage moves on when it is empty or the stage after it moves on
  always_comb begin
    adv[NS-1] = !vld[NS-1] || !hsv_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign pixel_stall = !adv[0];

  // stage one: max, min, delta and hue numerator
  always_comb begin
    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  d;
    logic [10:0] d11;
    mx  = (red > green) ? red : green;
    mx  = (mx > blue) ? mx : blue;
    mn  = (red < green) ? red : green;
    mn  = (mn < blue) ? mn : blue;
    d   = mx - mn;
    d11 = {3'b000, d};
    if (mx == red) begin
      if (green >= blue) begin
        prep_next.n = {3'b000, green} - {3'b000, blue};
      end else begin
        // wraps below zero by a full turn
        prep_next.n = (d11 << 2) + (d11 << 1) + {3'b000, green} - {3'b000, blue};
      end
    end else if (mx == green) begin
      prep_next.n = {3'b000, blue} + (d11 << 1) - {3'b000, red};
    end else begin
      prep_next.n = {3'b000, red} + (d11 << 2) - {3'b000, green};
    end
    prep_next.mx    = mx;
    prep_next.delta = d;
  end

  // stage two: dividends and divisors; grey divides zero by one
  // divider stages: two restoring steps each, most significant quotient bit first
  always_comb begin
    rgbhsv_pkg::quot_t t;
    logic [18:0]       hsh;
    logic [15:0]       ssh;
    int                sh;
    logic              grey;
    logic [18:0]       n19;
    logic [15:0]       d16;
    logic [10:0]       d11;
    grey = (prep.delta == 8'd0);
    n19  = {8'd0, prep.n};
    d16  = {8'd0, prep.delta};
    d11  = {3'b000, prep.delta};
    pipe_next[0].hrem   = grey ? 19'd0 : (n19 << 8) - n19;
    pipe_next[0].hden   = grey ? 11'd1 : (d11 << 2) + (d11 << 1);
    pipe_next[0].hq     = 8'd0;
    pipe_next[0].srem   = (d16 << 8) - d16;
    pipe_next[0].sden   = grey ? 8'd1 : prep.mx;
    pipe_next[0].sq     = 8'd0;
    pipe_next[0].bright = prep.mx;
    for (int j = 0; j < DS; j++) begin
      t = pipe[j];
      for (int k = 0; k < rgbhsv_pkg::BITS_PER_STAGE; k++) begin
        sh  = rgbhsv_pkg::QUOT_W - 1 - j * rgbhsv_pkg::BITS_PER_STAGE - k;
        hsh = {8'd0, t.hden} << sh;
        ssh = {8'd0, t.sden} << sh;
        if (t.hrem >= hsh) begin
          t.hrem = t.hrem - hsh;
          t.hq   = {t.hq[6:0], 1'b1};
        end else begin
          t.hq   = {t.hq[6:0], 1'b0};
        end
        if (t.srem >= ssh) begin
          t.srem = t.srem - ssh;
          t.sq   = {t.sq[6:0], 1'b1};
        end else begin
          t.sq   = {t.sq[6:0], 1'b0};
        end
      end
      pipe_next[j+1] = t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= pixel_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      prep <= prep_next;
    end
    for (int k = 0; k <= DS; k++) begin
      if (adv[k+1]) begin
        pipe[k] <= pipe_next[k];
      end
    end
  end

  assign hsv_valid  = vld[NS-1];
  assign hue        = pipe[DS].hq;
  assign saturation = pipe[DS].sq;
  assign brightness = pipe[DS].bright;

`ifndef SYNTHESIS
  // zero saturation only comes from a grey pixel, whose hue is zero
  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && saturation == 8'd0 |-> hue == 8'd0)
    else $error("grey pixel with non-zero hue");

  // the hue quotient stays below a full turn
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> hue != 8'hFF)
    else $error("hue reached a full turn");

  // black gives no saturation
  a_black: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && brightness == 8'd0 |-> saturation == 8'd0)
    else $error("black pixel with saturation");

  // input is only held off when every stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> vld == {NS{1'b1}} && hsv_stall)
    else $error("input stalled with room in the pipeline");
`endif

endmodule

### bench/tb.sv
// self-checking testbench for the rgb to hsv pixel converter
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [rgbhsv_pkg::PIX_W-1:0] r;
    logic [rgbhsv_pkg::PIX_W-1:0] g;
    logic [rgbhsv_pkg::PIX_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic [rgbhsv_pkg::QUOT_W-1:0] hue;
    logic [rgbhsv_pkg::QUOT_W-1:0] sat;
    logic [rgbhsv_pkg::PIX_W-1:0]  bright;
  } hsv_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       pixel_valid = 1'b0;
  logic       pixel_stall;
  logic [7:0] red = 8'd0;
  logic [7:0] green = 8'd0;
  logic [7:0] blue = 8'd0;
  logic       hsv_valid;
  logic       hsv_stall = 1'b0;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] brightness;

  rgb_t pixel_queue[$];
  hsv_t hsv_expected[$];
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   phase_no = 0;
  int   error_count = 0;
  logic long_hold = 1'b0;

  rgb_to_hsv_converter u_top (
    .clk        (clk),
    .rst        (rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .hsv_valid  (hsv_valid),
    .hsv_stall  (hsv_stall),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // exact integer conversion, every quotient truncating
  function automatic hsv_t hsv_of(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b);
    logic [rgbhsv_pkg::PIX_W-1:0]     mx;
    logic [rgbhsv_pkg::PIX_W-1:0]     mn;
    logic [rgbhsv_pkg::PIX_W-1:0]     delta;
    logic [rgbhsv_pkg::HUE_DEN_W-1:0] n;
    logic [rgbhsv_pkg::HUE_DEN_W-1:0] hue_den;
    logic [rgbhsv_pkg::HUE_NUM_W-1:0] hue_num;
    logic [rgbhsv_pkg::SAT_NUM_W-1:0] sat_num;
    hsv_t                             res;
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    delta = mx - mn;
    res.hue = '0;
    res.sat = '0;
    res.bright = mx;
    if (delta != 0) begin
      // sector picked by the first channel equal to max: red, then green, then blue
      if (mx == r) begin
        if (g >= b) n = 11'(g - b);
        else n = 11'(6 * delta + g - b);
      end else if (mx == g) begin
        n = 11'(b + 2 * delta - r);
      end else begin
        n = 11'(r + 4 * delta - g);
      end
      hue_den = 11'(6 * delta);
      hue_num = 19'(255 * n);
      sat_num = 16'(255 * delta);
      res.hue = 8'(hue_num / hue_den);
      res.sat = 8'(sat_num / mx);
    end
    return res;
  endfunction

  function automatic rgb_t random_pixel();
    rgb_t px;
    int   hi;
    int   lo;
    int   base;
    case ($urandom_range(9))
      4: begin
        px.r = 8'($urandom_range(255));
        px.g = px.r;
        px.b = px.r;
      end
      5: begin
        // two channels share the maximum
        hi = $urandom_range(255, 1);
        lo = $urandom_range(hi - 1, 0);
        case ($urandom_range(2))
          0: px = {8'(hi), 8'(hi), 8'(lo)};
          1: px = {8'(lo), 8'(hi), 8'(hi)};
          default: px = {8'(hi), 8'(lo), 8'(hi)};
        endcase
      end
      6: begin
        base = $urandom_range(254);
        px.r = 8'(base + $urandom_range(1));
        px.g = 8'(base + $urandom_range(1));
        px.b = 8'(base + $urandom_range(1));
      end
      7: begin
        px.r = $urandom_range(1) ? 8'd255 - 8'($urandom_range(1)) : 8'($urandom_range(1));
        px.g = $urandom_range(1) ? 8'd255 - 8'($urandom_range(1)) : 8'($urandom_range(1));
        px.b = $urandom_range(1) ? 8'd255 - 8'($urandom_range(1)) : 8'($urandom_range(1));
      end
      8: begin
        px.r = 8'($urandom_range(255));
        px.g = 8'($urandom_range(255));
        px.b = 8'($urandom_range(255));
        case ($urandom_range(2))
          0: px.r = 8'd255;
          1: px.g = 8'd255;
          default: px.b = 8'd255;
        endcase
      end
      9: begin
        px.r = 8'($urandom_range(3));
        px.g = 8'($urandom_range(3));
        px.b = 8'($urandom_range(3));
      end
      default: begin
        px.r = 8'($urandom_range(255));
        px.g = 8'($urandom_range(255));
        px.b = 8'($urandom_range(255));
      end
    endcase
    return px;
  endfunction

  // driver: present the next pending pixel, hold it while stalled
  always @(posedge clk) begin : pixel_drive
    rgb_t px;
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && !pixel_stall)
        hsv_expected = {hsv_expected, hsv_of(red, green, blue)};
      if (!(pixel_valid && pixel_stall)) begin
        if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          px = pixel_queue.pop_front();
          red <= px.r;
          green <= px.g;
          blue <= px.b;
          pixel_valid <= 1'b1;
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin : hsv_watch
    hsv_t want;
    if (rst) begin
      hsv_stall <= 1'b0;
    end else begin
      if (hsv_valid && !hsv_stall) begin
        if (hsv_expected.size() == 0) begin
          $display("%0t: unexpected result hue %0d saturation %0d brightness %0d",
                   $time, hue, saturation, brightness);
          error_count++;
        end else begin
          want = hsv_expected.pop_front();
          if (hue !== want.hue) begin
            $display("%0t: hue expected %0d actual %0d", $time, want.hue, hue);
            error_count++;
          end
          if (saturation !== want.sat) begin
            $display("%0t: saturation expected %0d actual %0d",
                     $time, want.sat, saturation);
            error_count++;
          end
          if (brightness !== want.bright) begin
            $display("%0t: brightness expected %0d actual %0d",
                     $time, want.bright, brightness);
            error_count++;
          end
        end
      end
      hsv_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // long receiver hold-off so the pipeline fills and backs up into the input
  initial begin
    wait (phase_no == 2);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (40) @(posedge clk);
    long_hold <= 1'b0;
  end

  task automatic push_pixel(input int r, input int g, input int b);
    pixel_queue = {pixel_queue, {8'(r), 8'(g), 8'(b)}};
  endtask

  task automatic drain();
    @(negedge clk);
    while (pixel_queue.size() > 0 || pixel_valid || hsv_expected.size() > 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int count, input int send_idle, input int recv_stall);
    @(negedge clk);
    phase_no++;
    send_idle_pct = send_idle;
    recv_stall_pct = recv_stall;
    repeat (count) pixel_queue = {pixel_queue, random_pixel()};
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    phase_no = 1;
    push_pixel(0, 0, 0);        // black
    push_pixel(255, 255, 255);  // white
    push_pixel(128, 128, 128);  // grey
    push_pixel(255, 0, 0);
    push_pixel(0, 255, 0);
    push_pixel(0, 0, 255);
    push_pixel(255, 255, 0);    // red and green tie, red sector wins
    push_pixel(0, 255, 255);    // green and blue tie, green sector wins
    push_pixel(255, 0, 255);    // red and blue tie, hue wraps
    push_pixel(255, 0, 1);      // largest hue
    push_pixel(255, 1, 0);
    push_pixel(1, 0, 0);
    push_pixel(0, 1, 0);
    push_pixel(0, 0, 1);
    push_pixel(1, 1, 0);
    push_pixel(255, 254, 254);
    push_pixel(254, 255, 255);
    push_pixel(200, 100, 50);
    push_pixel(50, 200, 100);
    push_pixel(100, 50, 200);
    push_pixel(128, 0, 255);
    push_pixel(170, 85, 85);
    drain();
    run_phase(245, 0, 0);
    run_phase(245, 56, 0);
    run_phase(245, 0, 56);
    run_phase(245, 35, 35);
    run_phase(245, 0, 0);
    repeat (12) @(posedge clk);
    if (error_count == 0 && hsv_expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
